// ===== rtl/gbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_pkg
// Shared types, codes and defaults of the greedy box track matcher.
// ----------------------------------------------------------------------------
package gbm_pkg;

    localparam int MAX_TRACKS_DEF = 64;
    localparam int COORD_BITS_DEF = 12;

    localparam int ID_W   = 16;
    localparam int CAT_W  = 4;
    localparam int DIST_W = 32;
    localparam int THR_W  = 16;
    localparam int LIM_W  = 13;
    localparam int CFG_W  = 16;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 3;
    localparam int LIM2_W = 2 * (LIM_W + 1);

    localparam logic [THR_W-1:0] THR_RESET = 16'd19661;
    localparam logic [LIM_W-1:0] LIM_RESET = 13'd50;

    // configuration register indexes
    localparam logic REG_IOU_THR  = 1'b0;
    localparam logic REG_DIST_LIM = 1'b1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MATCH = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_CLEARED = 3'd0;
    localparam logic [STAT_W-1:0] ST_LOADED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERLAP = 3'd3;
    localparam logic [STAT_W-1:0] ST_CENTRE  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE    = 3'd5;

    // read issued to the table
    typedef struct packed {
        logic vld;
        logic last;
        logic ent_valid;
    } t_tag;

    // per-slot flags from the evaluation pipeline
    typedef struct packed {
        logic vld;
        logic last;
        logic elig;
        logic id_hit;
        logic qual_iou;
        logic qual_dist;
    } t_flags;

endpackage

// ===== rtl/gbm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gbm_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_table
// Track table memory and the per-slot overlap / centroid evaluation pipeline.
// ----------------------------------------------------------------------------
module gbm_table
    import gbm_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int AW   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
    parameter int IAW  = 2 * COORD_BITS + 2,
    parameter int DW   = ((4 * COORD_BITS + 9) > LIM2_W) ? (4 * COORD_BITS + 9) : LIM2_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // write port
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [ID_W-1:0]       i_w_ident,
    input  logic [CAT_W-1:0]      i_w_cat,
    input  logic [COORD_BITS-1:0] i_w_x,
    input  logic [COORD_BITS-1:0] i_w_y,
    input  logic [COORD_BITS-1:0] i_w_w,
    input  logic [COORD_BITS-1:0] i_w_h,
    input  logic [DIST_W-1:0]     i_w_dist,
    // read issue
    input  t_tag                  i_tag,
    input  logic [AW-1:0]         i_raddr,
    // query
    input  logic [ID_W-1:0]       i_q_ident,
    input  logic [CAT_W-1:0]      i_q_cat,
    input  logic [COORD_BITS-1:0] i_q_x,
    input  logic [COORD_BITS-1:0] i_q_y,
    input  logic [COORD_BITS-1:0] i_q_w,
    input  logic [COORD_BITS-1:0] i_q_h,
    input  logic [COORD_BITS+1:0] i_q_cx,
    input  logic [COORD_BITS+1:0] i_q_cy,
    input  logic [IAW-1:0]        i_q_area,
    input  logic [THR_W-1:0]      i_thr,
    input  logic [LIM2_W-1:0]     i_lim2,
    // evaluated slot
    output t_flags                o_flags,
    output logic [IAW-1:0]        o_inter,
    output logic [IAW-1:0]        o_union,
    output logic [DW-1:0]         o_dsq,
    output logic [ID_W-1:0]       o_ident,
    output logic [DIST_W-1:0]     o_dist
);

    localparam int CW  = COORD_BITS;
    localparam int EW  = CW + 1;
    localparam int CTW = CW + 2;
    localparam int SQW = 2 * CTW;
    localparam int QW  = IAW + THR_W;
    localparam int RW  = ID_W + CAT_W + 4 * CW + DIST_W;

    logic [RW-1:0] w_rdata;

    gbm_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_TRACKS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata ({i_w_ident, i_w_cat, i_w_x, i_w_y, i_w_w, i_w_h, i_w_dist}),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    logic [ID_W-1:0]   e_ident;
    logic [CAT_W-1:0]  e_cat;
    logic [CW-1:0]     e_x, e_y, e_w, e_h;
    logic [DIST_W-1:0] e_dist;

    assign {e_ident, e_cat, e_x, e_y, e_w, e_h, e_dist} = w_rdata;

    // tag lines up with the read data
    t_tag r_tag0;

    // stage 1 combinational
    logic [CW-1:0]  c_x1, c_y1;
    logic [EW-1:0]  c_x2, c_y2, c_qe_x, c_qe_y, c_ee_x, c_ee_y;
    logic [CTW-1:0] c_ecx, c_ecy;

    always_comb begin
        c_x1   = (i_q_x > e_x) ? i_q_x : e_x;
        c_y1   = (i_q_y > e_y) ? i_q_y : e_y;
        c_qe_x = EW'(i_q_x) + EW'(i_q_w);
        c_qe_y = EW'(i_q_y) + EW'(i_q_h);
        c_ee_x = EW'(e_x) + EW'(e_w);
        c_ee_y = EW'(e_y) + EW'(e_h);
        c_x2   = (c_qe_x < c_ee_x) ? c_qe_x : c_ee_x;
        c_y2   = (c_qe_y < c_ee_y) ? c_qe_y : c_ee_y;
        c_ecx  = CTW'({e_x, 1'b0}) + CTW'(e_w);
        c_ecy  = CTW'({e_y, 1'b0}) + CTW'(e_h);
    end

    t_flags            r_f1, r_f2, r_f3, r_f4;
    logic [EW-1:0]     r_iw, r_ih;
    logic [CW-1:0]     r_ew, r_eh;
    logic [CTW-1:0]    r_dx, r_dy;
    logic [ID_W-1:0]   r_id1, r_id2, r_id3, r_id4;
    logic [DIST_W-1:0] r_ds1, r_ds2, r_ds3, r_ds4;
    logic [IAW-1:0]    r_ia2, r_qa2, r_ia3, r_ua3, r_ia4, r_ua4;
    logic [SQW-1:0]    r_dx2, r_dy2;
    logic [DW-1:0]     r_d3, r_d4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
            r_f1   <= '0;
            r_f2   <= '0;
            r_f3   <= '0;
            r_f4   <= '0;
        end else begin
            r_tag0 <= i_tag;
            // stage 1: edges, centre offsets, match flags
            r_f1.vld       <= r_tag0.vld;
            r_f1.last      <= r_tag0.last;
            r_f1.elig      <= r_tag0.ent_valid && (e_cat == i_q_cat);
            r_f1.id_hit    <= r_tag0.ent_valid && (e_ident == i_q_ident);
            r_f1.qual_iou  <= 1'b0;
            r_f1.qual_dist <= 1'b0;
            // stage 2..4 flags
            r_f2 <= r_f1;
            r_f3 <= r_f2;
            r_f4.vld       <= r_f3.vld;
            r_f4.last      <= r_f3.last;
            r_f4.elig      <= r_f3.elig;
            r_f4.id_hit    <= r_f3.id_hit;
            r_f4.qual_iou  <= (r_ia3 != '0) &&
                              ({r_ia3, {THR_W{1'b0}}} > QW'(i_thr) * QW'(r_ua3));
            r_f4.qual_dist <= r_d3 < DW'(i_lim2);
        end
    end

    always_ff @(posedge i_clk) begin
        r_iw  <= (c_x2 > EW'(c_x1)) ? c_x2 - EW'(c_x1) : '0;
        r_ih  <= (c_y2 > EW'(c_y1)) ? c_y2 - EW'(c_y1) : '0;
        r_ew  <= e_w;
        r_eh  <= e_h;
        r_dx  <= (i_q_cx > c_ecx) ? i_q_cx - c_ecx : c_ecx - i_q_cx;
        r_dy  <= (i_q_cy > c_ecy) ? i_q_cy - c_ecy : c_ecy - i_q_cy;
        r_id1 <= e_ident;
        r_ds1 <= e_dist;
        // stage 2: products
        r_ia2 <= IAW'(r_iw) * IAW'(r_ih);
        r_qa2 <= IAW'(r_ew) * IAW'(r_eh);
        r_dx2 <= SQW'(r_dx) * SQW'(r_dx);
        r_dy2 <= SQW'(r_dy) * SQW'(r_dy);
        r_id2 <= r_id1;
        r_ds2 <= r_ds1;
        // stage 3: union and squared distance
        r_ia3 <= r_ia2;
        r_ua3 <= i_q_area + r_qa2 - r_ia2;
        r_d3  <= DW'(r_dx2) + DW'(r_dy2);
        r_id3 <= r_id2;
        r_ds3 <= r_ds2;
        // stage 4: threshold tests
        r_ia4 <= r_ia3;
        r_ua4 <= r_ua3;
        r_d4  <= r_d3;
        r_id4 <= r_id3;
        r_ds4 <= r_ds3;
    end

    assign o_flags = r_f4;
    assign o_inter = r_ia4;
    assign o_union = r_ua4;
    assign o_dsq   = r_d4;
    assign o_ident = r_id4;
    assign o_dist  = r_ds4;

endmodule

// ===== rtl/greedy_box_track_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_track_matcher
// Previous-frame track table with greedy IoU / centroid association.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+--------------------------
//  request   | i_req_type .. i_distance_word           | start high, busy low
//  result    | o_status, o_matched_id, o_previous_dist | o_done, one cycle
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data         | write on i_cfg_we
//
//  clear and unused codes finish straight from idle; load and match scan every
//  slot of the table memory, one read a cycle, through the table read port,
//  the evaluation pipeline and a finish state.
//  busy drops as the result strobe rises; the receiver cannot stall.
//  synchronous reset empties the table at once through per-slot valid bits.
// ----------------------------------------------------------------------------
module greedy_box_track_matcher
    import gbm_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [ID_W-1:0]       i_track_id,
    input  logic [CAT_W-1:0]      i_category,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_w,
    input  logic [COORD_BITS-1:0] i_box_h,
    input  logic [DIST_W-1:0]     i_distance_word,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_done,
    output logic [STAT_W-1:0]     o_status,
    output logic [ID_W-1:0]       o_matched_id,
    output logic [DIST_W-1:0]     o_previous_distance
);

    localparam int CW  = COORD_BITS;
    localparam int AW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int FW  = $clog2(MAX_TRACKS + 1);
    localparam int IAW = 2 * CW + 2;
    localparam int DW  = ((4 * CW + 9) > LIM2_W) ? (4 * CW + 9) : LIM2_W;
    localparam int PW  = 2 * IAW;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TRACKS - 1);
    localparam logic [FW-1:0] FULL_CNT  = FW'(MAX_TRACKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;

    logic [THR_W-1:0]  r_thr;
    logic [LIM_W-1:0]  r_lim;
    logic [LIM2_W-1:0] r_lim2;
    logic [MAX_TRACKS-1:0] r_valid;
    logic [FW-1:0]     r_fill;

    // latched request
    logic [REQ_W-1:0]  r_req;
    logic [ID_W-1:0]   r_q_id;
    logic [CAT_W-1:0]  r_q_cat;
    logic [CW-1:0]     r_q_x, r_q_y, r_q_w, r_q_h;
    logic [CW+1:0]     r_q_cx, r_q_cy;
    logic [IAW-1:0]    r_q_area;
    logic [DIST_W-1:0] r_q_dist;

    // scan control
    logic [AW-1:0] r_addr;
    logic          r_issuing;
    logic [AW-1:0] r_slot;

    // running best candidates
    logic              r_hit_found, r_ov_found, r_ds_found;
    logic [AW-1:0]     r_hit_slot, r_ov_slot, r_ds_slot;
    logic [IAW-1:0]    r_b_inter, r_b_union;
    logic [DW-1:0]     r_b_dsq;
    logic [ID_W-1:0]   r_ov_id, r_ds_id;
    logic [DIST_W-1:0] r_ov_dist, r_ds_dist;

    logic              r_done;
    logic [STAT_W-1:0] r_status;
    logic [ID_W-1:0]   r_mid;
    logic [DIST_W-1:0] r_mdist;

    logic              r_we;
    logic [AW-1:0]     r_waddr;

    t_tag              w_tag;
    t_flags            w_f;
    logic [IAW-1:0]    w_inter, w_union;
    logic [DW-1:0]     w_dsq;
    logic [ID_W-1:0]   w_ident;
    logic [DIST_W-1:0] w_dist;
    logic              w_better_ov, w_better_ds;

    assign w_tag.vld       = (r_state == S_SCAN) && r_issuing;
    assign w_tag.last      = (r_addr == LAST_SLOT);
    assign w_tag.ent_valid = r_valid[r_addr];

    gbm_table #(
        .MAX_TRACKS (MAX_TRACKS),
        .COORD_BITS (COORD_BITS),
        .AW         (AW),
        .IAW        (IAW),
        .DW         (DW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (r_we),
        .i_waddr   (r_waddr),
        .i_w_ident (r_q_id),
        .i_w_cat   (r_q_cat),
        .i_w_x     (r_q_x),
        .i_w_y     (r_q_y),
        .i_w_w     (r_q_w),
        .i_w_h     (r_q_h),
        .i_w_dist  (r_q_dist),
        .i_tag     (w_tag),
        .i_raddr   (r_addr),
        .i_q_ident (r_q_id),
        .i_q_cat   (r_q_cat),
        .i_q_x     (r_q_x),
        .i_q_y     (r_q_y),
        .i_q_w     (r_q_w),
        .i_q_h     (r_q_h),
        .i_q_cx    (r_q_cx),
        .i_q_cy    (r_q_cy),
        .i_q_area  (r_q_area),
        .i_thr     (r_thr),
        .i_lim2    (r_lim2),
        .o_flags   (w_f),
        .o_inter   (w_inter),
        .o_union   (w_union),
        .o_dsq     (w_dsq),
        .o_ident   (w_ident),
        .o_dist    (w_dist)
    );

    // exact rational compare by cross products; strict, so ties keep the lower slot
    assign w_better_ov = !r_ov_found ||
                         (PW'(w_inter) * PW'(r_b_union) > PW'(r_b_inter) * PW'(w_union));
    assign w_better_ds = !r_ds_found || (w_dsq < r_b_dsq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_lim       <= LIM_RESET;
            r_valid     <= '0;
            r_fill      <= '0;
            r_issuing   <= 1'b0;
            r_done      <= 1'b0;
            r_we        <= 1'b0;
            r_hit_found <= 1'b0;
            r_ov_found  <= 1'b0;
            r_ds_found  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_we   <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IOU_THR:  r_thr <= i_cfg_data[THR_W-1:0];
                    REG_DIST_LIM: r_lim <= i_cfg_data[LIM_W-1:0];
                    default:      r_thr <= r_thr;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req    <= i_req_type;
                        r_q_id   <= i_track_id;
                        r_q_cat  <= i_category;
                        r_q_x    <= i_box_x;
                        r_q_y    <= i_box_y;
                        r_q_w    <= i_box_w;
                        r_q_h    <= i_box_h;
                        r_q_dist <= i_distance_word;
                        r_q_cx   <= (CW + 2)'({i_box_x, 1'b0}) + (CW + 2)'(i_box_w);
                        r_q_cy   <= (CW + 2)'({i_box_y, 1'b0}) + (CW + 2)'(i_box_h);
                        r_q_area <= IAW'(i_box_w) * IAW'(i_box_h);
                        r_lim2   <= LIM2_W'({r_lim, 1'b0}) * LIM2_W'({r_lim, 1'b0});
                        r_mid    <= '0;
                        r_mdist  <= '0;
                        if (i_req_type == REQ_CLEAR) begin
                            r_valid  <= '0;
                            r_fill   <= '0;
                            r_status <= ST_CLEARED;
                            r_done   <= 1'b1;
                        end else if (i_req_type == REQ_LOAD || i_req_type == REQ_MATCH) begin
                            r_state     <= S_SCAN;
                            r_addr      <= '0;
                            r_slot      <= '0;
                            r_issuing   <= 1'b1;
                            r_hit_found <= 1'b0;
                            r_ov_found  <= 1'b0;
                            r_ds_found  <= 1'b0;
                        end else begin
                            r_status <= ST_NONE;
                            r_done   <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issuing) begin
                        if (r_addr == LAST_SLOT) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (w_f.vld) begin
                        r_slot <= r_slot + 1'b1;
                        if (w_f.id_hit && !r_hit_found) begin
                            r_hit_found <= 1'b1;
                            r_hit_slot  <= r_slot;
                        end
                        if (w_f.elig && w_f.qual_iou && w_better_ov) begin
                            r_ov_found <= 1'b1;
                            r_ov_slot  <= r_slot;
                            r_b_inter  <= w_inter;
                            r_b_union  <= w_union;
                            r_ov_id    <= w_ident;
                            r_ov_dist  <= w_dist;
                        end
                        if (w_f.elig && w_f.qual_dist && w_better_ds) begin
                            r_ds_found <= 1'b1;
                            r_ds_slot  <= r_slot;
                            r_b_dsq    <= w_dsq;
                            r_ds_id    <= w_ident;
                            r_ds_dist  <= w_dist;
                        end
                        if (w_f.last) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (r_req == REQ_LOAD) begin
                        // duplicate id rewrites in place, otherwise append
                        if (r_hit_found) begin
                            r_we     <= 1'b1;
                            r_waddr  <= r_hit_slot;
                            r_valid[r_hit_slot] <= 1'b1;
                            r_status <= ST_LOADED;
                        end else if (r_fill != FULL_CNT) begin
                            r_we     <= 1'b1;
                            r_waddr  <= r_fill[AW-1:0];
                            r_valid[r_fill[AW-1:0]] <= 1'b1;
                            r_fill   <= r_fill + 1'b1;
                            r_status <= ST_LOADED;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end else if (r_ov_found) begin
                        r_status <= ST_OVERLAP;
                        r_mid    <= r_ov_id;
                        r_mdist  <= r_ov_dist;
                        r_valid[r_ov_slot] <= 1'b0;
                    end else if (r_ds_found) begin
                        r_status <= ST_CENTRE;
                        r_mid    <= r_ds_id;
                        r_mdist  <= r_ds_dist;
                        r_valid[r_ds_slot] <= 1'b0;
                    end else begin
                        r_status <= ST_NONE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy                = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_matched_id        = r_mid;
    assign o_previous_distance = r_mdist;

    // the result transfer always lands with the block free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count beyond table depth");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_LOAD || i_req_type == REQ_MATCH)) |=> busy)
        else $error("load or match did not start a scan");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OVERLAP && o_status != ST_CENTRE)
            |-> (o_matched_id == '0 && o_previous_distance == '0))
        else $error("nonzero payload without a match");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> (o_done && r_state == S_IDLE))
        else $error("finish did not deliver a result");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy box track matcher: table clears, track
// loads (duplicates, full table) and IoU / centroid matches are driven under
// several threshold settings and checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
    import gbm_pkg::*;

    localparam int SLOTS = 64;
    localparam int CB    = 12;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int ITEM_GOAL  = 1050;
    localparam int QUIET_FROM = 900;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   ident;
        logic [DIST_W-1:0] prev_dist;
    } t_match_result;

    typedef struct packed {
        logic [CAT_W-1:0] cat;
        logic [CB-1:0]    x;
        logic [CB-1:0]    y;
        logic [CB-1:0]    w;
        logic [CB-1:0]    h;
    } t_track_box;

    class track_scoreboard;
        bit                valid [SLOTS];
        bit [CAT_W-1:0]    cat   [SLOTS];
        bit [CB-1:0]       bx [SLOTS], by [SLOTS], bw [SLOTS], bh [SLOTS];
        bit [ID_W-1:0]     ident [SLOTS];
        bit [DIST_W-1:0]   dword [SLOTS];
        int                fill;
        bit [THR_W-1:0]    thr;
        bit [LIM_W-1:0]    lim;
        t_match_result     pending [$];
        int                errors;
        int                checked;
        int                n_overlap, n_centre, n_full;

        function new();
            foreach (valid[i]) valid[i] = 0;
            fill = 0;
            thr = THR_RESET;
            lim = LIM_RESET;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == REG_IOU_THR) thr = data[THR_W-1:0];
            else lim = data[LIM_W-1:0];
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                   logic [CAT_W-1:0] c, logic [CB-1:0] x,
                                   logic [CB-1:0] y, logic [CB-1:0] w,
                                   logic [CB-1:0] h, logic [DIST_W-1:0] dw);
            t_match_result r;
            int slot, best;
            longint unsigned x1, y1, x2, y2, ia, ua, b_ia, b_ua, d, b_d, lim2;
            longint unsigned cx, cy, ex, ey, dx, dy;
            r = '0;
            r.status = ST_NONE;
            best = -1;
            if (req == REQ_CLEAR) begin
                foreach (valid[i]) valid[i] = 0;
                fill = 0;
                r.status = ST_CLEARED;
            end else if (req == REQ_LOAD) begin
                slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && valid[i] && ident[i] == id) slot = i;
                if (slot < 0 && fill < SLOTS) begin
                    slot = fill;
                    fill++;
                end
                if (slot >= 0) begin
                    valid[slot] = 1; ident[slot] = id; cat[slot] = c;
                    bx[slot] = x; by[slot] = y; bw[slot] = w; bh[slot] = h;
                    dword[slot] = dw;
                    r.status = ST_LOADED;
                end else begin
                    r.status = ST_FULL;
                    n_full++;
                end
            end else if (req == REQ_MATCH) begin
                b_ia = 0; b_ua = 1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!valid[i] || cat[i] != c) continue;
                    x1 = (x > bx[i]) ? x : bx[i];
                    y1 = (y > by[i]) ? y : by[i];
                    x2 = ((x + 64'(w)) < (bx[i] + 64'(bw[i]))) ? x + 64'(w)
                                                                : bx[i] + 64'(bw[i]);
                    y2 = ((y + 64'(h)) < (by[i] + 64'(bh[i]))) ? y + 64'(h)
                                                                : by[i] + 64'(bh[i]);
                    ia = (x2 > x1 && y2 > y1) ? (x2 - x1) * (y2 - y1) : 0;
                    ua = 64'(w) * h + 64'(bw[i]) * bh[i] - ia;
                    if (ia == 0 || ia * 65536 <= 64'(thr) * ua) continue;
                    // candidates compared as rationals by cross product
                    if (best < 0 || ia * b_ua > b_ia * ua) begin
                        best = i; b_ia = ia; b_ua = ua;
                    end
                end
                if (best >= 0) begin
                    r.status = ST_OVERLAP;
                    n_overlap++;
                end else begin
                    // doubled centres, so compare with (2*limit)^2
                    lim2 = (64'(lim) * 2) * (64'(lim) * 2);
                    cx = 2 * 64'(x) + w;
                    cy = 2 * 64'(y) + h;
                    b_d = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!valid[i] || cat[i] != c) continue;
                        ex = 2 * 64'(bx[i]) + bw[i];
                        ey = 2 * 64'(by[i]) + bh[i];
                        dx = (cx > ex) ? cx - ex : ex - cx;
                        dy = (cy > ey) ? cy - ey : ey - cy;
                        d = dx * dx + dy * dy;
                        if (d >= lim2) continue;
                        if (best < 0 || d < b_d) begin
                            best = i; b_d = d;
                        end
                    end
                    if (best >= 0) begin
                        r.status = ST_CENTRE;
                        n_centre++;
                    end
                end
                if (best >= 0) begin
                    r.ident = ident[best];
                    r.prev_dist = dword[best];
                    valid[best] = 0;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [ID_W-1:0] id,
                                   logic [DIST_W-1:0] dw);
            t_match_result e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: status %0d id %0d", st, id);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (id !== e.ident) begin
                $error("matched_id: expected %0d, got %0d", e.ident, id);
                errors++;
            end
            if (dw !== e.prev_dist) begin
                $error("previous_distance: expected %0h, got %0h", e.prev_dist, dw);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [REQ_W-1:0]  i_req_type;
    logic [ID_W-1:0]   i_track_id;
    logic [CAT_W-1:0]  i_category;
    logic [CB-1:0]     i_box_x, i_box_y, i_box_w, i_box_h;
    logic [DIST_W-1:0] i_distance_word;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [ID_W-1:0]   o_matched_id;
    logic [DIST_W-1:0] o_previous_distance;

    track_scoreboard tracks = new();
    t_track_box      loaded [$];
    int              n_items;
    int              n_cfg;
    bit              quiet;

    greedy_box_track_matcher i_dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_req_type, .i_track_id, .i_category,
        .i_box_x, .i_box_y, .i_box_w, .i_box_h, .i_distance_word,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_done, .o_status, .o_matched_id, .o_previous_distance
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20 * 600000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracks.check_result(o_status, o_matched_id, o_previous_distance);
    end

    // one request transfer; start is left high for a back-to-back follower unless a random gap drops it
    task automatic send(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                        logic [CAT_W-1:0] c, logic [CB-1:0] x, logic [CB-1:0] y,
                        logic [CB-1:0] w, logic [CB-1:0] h, logic [DIST_W-1:0] dw);
        start <= 1'b1;
        i_req_type <= req; i_track_id <= id; i_category <= c;
        i_box_x <= x; i_box_y <= y; i_box_w <= w; i_box_h <= h;
        i_distance_word <= dw;
        do @(posedge i_clk); while (busy);
        tracks.note_request(req, id, c, x, y, w, h, dw);
        n_items++;
        if (req == REQ_LOAD) loaded.push_back({c, x, y, w, h});
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracks.pending.size() != 0) @(posedge i_clk);
        repeat (MAX_TRACKS_DEF + 16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        tracks.set_reg(idx, data);
        n_cfg++;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CB-1:0] jitter(logic [CB-1:0] v, int span);
        int t;
        t = int'(v) + $urandom_range(0, 2 * span) - span;
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
        return t[CB-1:0];
    endfunction

    // clear, fill with tracks, then try to re-find them in the next frame, among random requests
    task automatic frame();
        int n_load, n_match, k, pool;
        t_track_box b;
        logic [CB-1:0] x, y;
        loaded.delete();
        send(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom);
        n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                             : $urandom_range(1, 14);
        pool = $urandom_range(0, 1) ? 30 : 65535;
        for (int i = 0; i < n_load; i++) begin
            x = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600);
            y = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600);
            send(REQ_LOAD, $urandom_range(0, pool), $urandom_range(0, 3), x, y,
                 $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 120),
                 $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 120),
                 $urandom);
        end
        n_match = $urandom_range(1, n_load + 2);
        for (int i = 0; i < n_match; i++) begin
            k = $urandom_range(0, 9);
            if (k < 7 && loaded.size() != 0) begin
                b = loaded[$urandom_range(0, loaded.size() - 1)];
                send(REQ_MATCH, $urandom, (k == 6) ? $urandom_range(0, 3) : b.cat,
                     jitter(b.x, k < 3 ? 8 : 60), jitter(b.y, k < 3 ? 8 : 60),
                     jitter(b.w, 10), jitter(b.h, 10), $urandom);
            end else if (k == 9) begin
                send($urandom_range(0, 1) ? REQ_SPARE : REQ_LOAD, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                send(REQ_MATCH, $urandom, $urandom_range(0, 3), $urandom,
                     $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] thr_set [4];
        logic [CFG_W-1:0] lim_set [4];
        int phase;
        i_rst_n = 1'b0; start = 1'b0; i_req_type = REQ_CLEAR; i_track_id = '0;
        i_category = '0; i_box_x = '0; i_box_y = '0; i_box_w = '0; i_box_h = '0;
        i_distance_word = '0; i_cfg_we = 1'b0; i_cfg_idx = REG_IOU_THR;
        i_cfg_data = '0;
        n_items = 0; n_cfg = 0; quiet = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset thresholds, extremes, duplicate, ties, empty boxes
        send(REQ_CLEAR, '1, '1, '1, '1, '1, '1, '1);
        send(REQ_LOAD, 16'hFFFF, 4'hF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, '1);
        send(REQ_LOAD, 16'd0, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0, '0);
        send(REQ_LOAD, 16'd7, 4'd1, 12'd100, 12'd100, 12'd40, 12'd40, 32'hA5A5_0001);
        send(REQ_LOAD, 16'd8, 4'd1, 12'd100, 12'd100, 12'd40, 12'd40, 32'h0000_0002);
        send(REQ_LOAD, 16'd7, 4'd1, 12'd300, 12'd300, 12'd20, 12'd20, 32'h0000_0003);
        send(REQ_MATCH, '0, 4'd1, 12'd100, 12'd100, 12'd40, 12'd40, '0);
        send(REQ_MATCH, '0, 4'd1, 12'd310, 12'd305, 12'd5, 12'd5, '0);
        send(REQ_MATCH, '0, 4'hF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, '0);
        send(REQ_MATCH, '0, 4'd0, 12'd10, 12'd10, 12'd0, 12'd4, '0);
        send(REQ_MATCH, '0, 4'd1, 12'd2000, 12'd2000, 12'd10, 12'd10, '0);
        send(REQ_MATCH, '0, 4'd1, 12'd100, 12'd100, 12'd40, 12'd40, '0);
        send(REQ_SPARE, '1, '1, '1, '1, '1, '1, '1);
        send(REQ_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        send(REQ_MATCH, '0, 4'd1, 12'd100, 12'd100, 12'd40, 12'd40, '0);

        thr_set = '{16'd0, 16'hFFFF, 16'd19661, 16'd40000};
        lim_set = '{16'd0, 16'd8191, 16'd50, 16'd400};
        phase = 0;
        while (n_items < ITEM_GOAL) begin
            if (n_items >= 150 * (phase + 1) - 60) begin
                settle();
                write_reg(REG_IOU_THR, phase < 4 ? thr_set[phase] : $urandom);
                write_reg(REG_DIST_LIM, phase < 4 ? lim_set[(phase + 1) % 4]
                                                  : $urandom_range(0, 8191));
                phase++;
            end
            quiet = (n_items >= QUIET_FROM);
            frame();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (tracks.pending.size() != 0) @(posedge i_clk);
        repeat (MAX_TRACKS_DEF + 16) @(posedge i_clk);

        $display("covered %0d requests, %0d results checked, %0d register writes",
                 n_items, tracks.checked, n_cfg);
        $display("overlap matches %0d, centroid matches %0d, full-table drops %0d",
                 tracks.n_overlap, tracks.n_centre, tracks.n_full);
        if (tracks.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gbm_pkg.sv
rtl/gbm_ram.sv
rtl/gbm_table.sv
rtl/greedy_box_track_matcher.sv
tb/sv/tb.sv
